// File: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and the event priority encoder for the button
// press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int NUM_BTN   = 3;
    localparam int HOLD_W    = 8;
    localparam int LIMIT_W   = 8;
    localparam int IDLE_W    = 16;
    localparam int BRIGHT_W  = 8;
    localparam int CODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;

    // Button lanes and flag bit positions
    localparam int BTN_LEFT  = 0;
    localparam int BTN_RIGHT = 1;
    localparam int BTN_OK    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BRT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_BRT     = 3'd4;

    // Configuration reset values
    localparam logic [LIMIT_W-1:0]  RST_SHORT_LIMIT = 8'd50;
    localparam logic [LIMIT_W-1:0]  RST_LONG_LIMIT  = 8'd100;
    localparam logic [IDLE_W-1:0]   RST_IDLE_LIMIT  = 16'd6000;
    localparam logic [BRIGHT_W-1:0] RST_NORMAL_BRT  = 8'd255;
    localparam logic [BRIGHT_W-1:0] RST_DIM_BRT     = 8'd1;

    // Event codes
    localparam logic [CODE_W-1:0] EV_NONE        = 3'd0;
    localparam logic [CODE_W-1:0] EV_OK_SHORT    = 3'd1;
    localparam logic [CODE_W-1:0] EV_RIGHT_LONG  = 3'd2;
    localparam logic [CODE_W-1:0] EV_LEFT_LONG   = 3'd3;
    localparam logic [CODE_W-1:0] EV_LEFT_SHORT  = 3'd4;
    localparam logic [CODE_W-1:0] EV_RIGHT_SHORT = 3'd5;
    localparam logic [CODE_W-1:0] EV_OK_LONG     = 3'd6;

    typedef struct packed {
        logic [LIMIT_W-1:0]  short_limit;
        logic [LIMIT_W-1:0]  long_limit;
        logic [IDLE_W-1:0]   idle_limit;
        logic [BRIGHT_W-1:0] normal_brightness;
        logic [BRIGHT_W-1:0] dim_brightness;
    } cfg_t;

    typedef struct packed {
        logic short_hit;
        logic long_hit;
    } lane_hit_t;

    typedef struct packed {
        logic [CODE_W-1:0]   event_code;
        logic [BRIGHT_W-1:0] backlight_level;
        logic                backlight_dimmed;
    } result_t;

    function automatic logic [CODE_W-1:0] pending_code(
        input logic [NUM_BTN-1:0] short_flags,
        input logic [NUM_BTN-1:0] long_flags
    );
        logic [CODE_W-1:0] code;
        code = EV_NONE;
        if (short_flags[BTN_OK])
            code = EV_OK_SHORT;
        else if (long_flags[BTN_RIGHT])
            code = EV_RIGHT_LONG;
        else if (long_flags[BTN_LEFT])
            code = EV_LEFT_LONG;
        else if (short_flags[BTN_LEFT])
            code = EV_LEFT_SHORT;
        else if (short_flags[BTN_RIGHT])
            code = EV_RIGHT_SHORT;
        else if (long_flags[BTN_OK])
            code = EV_OK_LONG;
        return code;
    endfunction

endpackage

// File: rtl/bpc_lane.sv
// ----------------------------------------------------------------------------
// bpc_lane
// One button lane: hold counter with saturation and release classification.
// ----------------------------------------------------------------------------
module bpc_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick,
    input  logic                          level,
    input  logic [bpc_pkg::LIMIT_W-1:0]   short_limit,
    input  logic [bpc_pkg::LIMIT_W-1:0]   long_limit,
    output bpc_pkg::lane_hit_t            hit
);
    import bpc_pkg::*;

    logic [HOLD_W-1:0] count_reg;
    logic [HOLD_W-1:0] count_next;
    logic              released;

    // Pin is active low: high level on a tick means release
    assign released = tick && level;

    always_comb
    begin
        hit.short_hit = 1'b0;
        hit.long_hit  = 1'b0;
        if (released)
        begin
            if ((count_reg != '0) && (count_reg < short_limit))
                hit.short_hit = 1'b1;
            else if ((count_reg > long_limit) && (count_reg < HOLD_MAX))
                hit.long_hit = 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (released)
            count_next = '0;
        else if (tick && (count_reg < HOLD_MAX))
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// File: rtl/bpc_merge.sv
// ----------------------------------------------------------------------------
// bpc_merge
// Merging stage: sticky press flags, priority encoding, acknowledge and
// backlight idle timer. Produces the result of the current transaction.
// ----------------------------------------------------------------------------
module bpc_merge (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     accept,
    input  logic                                     ack,
    input  bpc_pkg::cfg_t                            cfg,
    input  bpc_pkg::lane_hit_t [bpc_pkg::NUM_BTN-1:0] hits,
    output bpc_pkg::result_t                         res
);
    import bpc_pkg::*;

    logic [NUM_BTN-1:0]  short_flags_reg;
    logic [NUM_BTN-1:0]  short_flags_next;
    logic [NUM_BTN-1:0]  long_flags_reg;
    logic [NUM_BTN-1:0]  long_flags_next;
    logic [IDLE_W-1:0]   idle_count_reg;
    logic [IDLE_W-1:0]   idle_count_next;
    logic [BRIGHT_W-1:0] level_reg;
    logic [BRIGHT_W-1:0] level_next;
    logic                dimmed_reg;
    logic                dimmed_next;
    logic [IDLE_W-1:0]   idle_inc;
    logic [CODE_W-1:0]   shown_code;
    logic [CODE_W-1:0]   new_code;

    assign shown_code = pending_code(short_flags_reg, long_flags_reg);
    assign idle_inc   = idle_count_reg + 1'b1;

    always_comb
    begin
        short_flags_next = short_flags_reg;
        long_flags_next  = long_flags_reg;
        if (accept)
        begin
            if (ack)
            begin
                // Drop the flag behind the event on display
                case (shown_code)
                    EV_OK_SHORT:    short_flags_next[BTN_OK]    = 1'b0;
                    EV_RIGHT_LONG:  long_flags_next[BTN_RIGHT]  = 1'b0;
                    EV_LEFT_LONG:   long_flags_next[BTN_LEFT]   = 1'b0;
                    EV_LEFT_SHORT:  short_flags_next[BTN_LEFT]  = 1'b0;
                    EV_RIGHT_SHORT: short_flags_next[BTN_RIGHT] = 1'b0;
                    EV_OK_LONG:     long_flags_next[BTN_OK]     = 1'b0;
                    default:        ;
                endcase
            end
            else
            begin
                for (int i = 0; i < NUM_BTN; i++)
                begin
                    short_flags_next[i] = short_flags_reg[i] | hits[i].short_hit;
                    long_flags_next[i]  = long_flags_reg[i] | hits[i].long_hit;
                end
            end
        end
    end

    assign new_code = pending_code(short_flags_next, long_flags_next);

    always_comb
    begin
        idle_count_next = idle_count_reg;
        level_next      = level_reg;
        dimmed_next     = dimmed_reg;
        if (accept && !ack)
        begin
            if (new_code == EV_NONE)
            begin
                if (idle_inc >= cfg.idle_limit)
                begin
                    idle_count_next = '0;
                    level_next      = cfg.dim_brightness;
                    dimmed_next     = 1'b1;
                end
                else
                begin
                    idle_count_next = idle_inc;
                end
            end
            else
            begin
                idle_count_next = '0;
                level_next      = cfg.normal_brightness;
                dimmed_next     = 1'b0;
            end
        end
    end

    assign res.event_code       = new_code;
    assign res.backlight_level  = level_next;
    assign res.backlight_dimmed = dimmed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_flags_reg <= '0;
            long_flags_reg  <= '0;
            idle_count_reg  <= '0;
            level_reg       <= RST_NORMAL_BRT;
            dimmed_reg      <= 1'b0;
        end
        else
        begin
            short_flags_reg <= short_flags_next;
            long_flags_reg  <= long_flags_next;
            idle_count_reg  <= idle_count_next;
            level_reg       <= level_next;
            dimmed_reg      <= dimmed_next;
        end
    end

endmodule

// File: rtl/button_press_classifier_core.sv
// ----------------------------------------------------------------------------
// button_press_classifier_core
// Short/long press classifier for three buttons with backlight idle dimming.
//
//   channel  | signals                                    | transfer
//   ---------+--------------------------------------------+-------------------
//   input    | in_valid/in_ready, action, *_level         | valid & ready
//   output   | out_valid/out_ready, event_code, backlight | valid & ready
//   config   | cfg_wr_en, cfg_index, cfg_data             | cfg_wr_en high
//
// One transaction per cycle while in_ready is high; the result is computed in
// the accepting cycle and written into the result queue, whose head drives
// the output. The merge stage and, on ticks, the lanes update in that cycle.
// A two-entry result queue decouples the sides: input is taken while it has
// a free slot, so a stalled output costs two items of slack before in_ready
// drops. Reset clears counters, flags and queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_press_classifier_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic                            left_level,
    input  logic                            right_level,
    input  logic                            ok_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bpc_pkg::CODE_W-1:0]      event_code,
    output logic [bpc_pkg::BRIGHT_W-1:0]    backlight_level,
    output logic                            backlight_dimmed,
    input  logic                            cfg_wr_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import bpc_pkg::*;

    cfg_t                      cfg_reg;
    cfg_t                      cfg_next;
    lane_hit_t [NUM_BTN-1:0]   hits;
    logic [NUM_BTN-1:0]        levels;
    result_t                   res;
    result_t                   slot0_reg;
    result_t                   slot0_next;
    result_t                   slot1_reg;
    result_t                   slot1_next;
    logic [1:0]                count_reg;
    logic [1:0]                count_next;
    logic                      push;
    logic                      pop;
    logic                      tick;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign tick      = push && !action;

    assign levels[BTN_LEFT]  = left_level;
    assign levels[BTN_RIGHT] = right_level;
    assign levels[BTN_OK]    = ok_level;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SHORT_LIMIT: cfg_next.short_limit       = cfg_data[LIMIT_W-1:0];
                REG_LONG_LIMIT:  cfg_next.long_limit        = cfg_data[LIMIT_W-1:0];
                REG_IDLE_LIMIT:  cfg_next.idle_limit        = cfg_data[IDLE_W-1:0];
                REG_NORMAL_BRT:  cfg_next.normal_brightness = cfg_data[BRIGHT_W-1:0];
                REG_DIM_BRT:     cfg_next.dim_brightness    = cfg_data[BRIGHT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_limit       <= RST_SHORT_LIMIT;
            cfg_reg.long_limit        <= RST_LONG_LIMIT;
            cfg_reg.idle_limit        <= RST_IDLE_LIMIT;
            cfg_reg.normal_brightness <= RST_NORMAL_BRT;
            cfg_reg.dim_brightness    <= RST_DIM_BRT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    for (genvar g = 0; g < NUM_BTN; g++)
    begin : g_lane
        bpc_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .tick        (tick),
            .level       (levels[g]),
            .short_limit (cfg_reg.short_limit),
            .long_limit  (cfg_reg.long_limit),
            .hit         (hits[g])
        );
    end

    bpc_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (push),
        .ack    (action),
        .cfg    (cfg_reg),
        .hits   (hits),
        .res    (res)
    );

    // Two-entry result queue, slot0 is the head
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    slot0_next = res;
                else
                    slot1_next = res;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                    slot0_next = res;
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign event_code       = slot0_reg.event_code;
    assign backlight_level  = slot0_reg.backlight_level;
    assign backlight_dimmed = slot0_reg.backlight_dimmed;

endmodule
